// ===== hdl/jsu_pkg.sv =====
// Shared types, constants and helper functions for the JSON string unescaper.
// Used by jsu_front, jsu_fifo, jsu_back and json_string_unescape_utf8.
package jsu_pkg;

  typedef enum logic [2:0] {
    PH_WAIT    = 3'd0,
    PH_BODY    = 3'd1,
    PH_ESC     = 3'd2,
    PH_HEX1    = 3'd3,
    PH_SEEK_BS = 3'd4,
    PH_SEEK_U  = 3'd5,
    PH_HEX2    = 3'd6
  } phase_t;

  localparam logic [3:0] ERR_NONE        = 4'd0;
  localparam logic [3:0] ERR_NO_QUOTE    = 4'd1;
  localparam logic [3:0] ERR_CONTROL     = 4'd2;
  localparam logic [3:0] ERR_OPEN_ESC    = 4'd3;
  localparam logic [3:0] ERR_BAD_ESC     = 4'd4;
  localparam logic [3:0] ERR_SHORT_UNI   = 4'd5;
  localparam logic [3:0] ERR_BAD_HEX     = 4'd6;
  localparam logic [3:0] ERR_UNPAIRED    = 4'd7;
  localparam logic [3:0] ERR_BAD_LOW_HEX = 4'd8;
  localparam logic [3:0] ERR_UNTERM      = 4'd9;

  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_U         = 8'h75;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  localparam logic [15:0] HI_SURR_MIN = 16'hD800;
  localparam logic [15:0] HI_SURR_MAX = 16'hDBFF;
  localparam logic [15:0] LO_SURR_MIN = 16'hDC00;
  localparam logic [15:0] LO_SURR_MAX = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE   = 21'h10000;

  typedef struct packed {
    logic [1:0]      last_idx;
    logic [3:0][7:0] bytes;
  } utf8_t;

  typedef struct packed {
    logic            is_byte;
    logic            done;
    logic [3:0]      err;
    logic [1:0]      last_idx;
    logic [3:0][7:0] bytes;
  } cmd_t;

  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic logic [8:0] simple_escape(input logic [7:0] c);
    logic [8:0] r;
    r = 9'd0;
    unique case (c)
      8'h22:   r = {1'b1, 8'h22};
      8'h5C:   r = {1'b1, 8'h5C};
      8'h2F:   r = {1'b1, 8'h2F};
      8'h62:   r = {1'b1, 8'h08};
      8'h66:   r = {1'b1, 8'h0C};
      8'h6E:   r = {1'b1, 8'h0A};
      8'h72:   r = {1'b1, 8'h0D};
      8'h74:   r = {1'b1, 8'h09};
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic utf8_t utf8_encode(input logic [20:0] cp);
    utf8_t r;
    r = '0;
    if (cp <= 21'h7F) begin
      r.last_idx = 2'd0;
      r.bytes[0] = cp[7:0];
    end else if (cp <= 21'h7FF) begin
      r.last_idx = 2'd1;
      r.bytes[0] = {3'b110, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'hFFFF) begin
      r.last_idx = 2'd2;
      r.bytes[0] = {4'b1110, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      r.last_idx = 2'd3;
      r.bytes[0] = {5'b11110, cp[20:18]};
      r.bytes[1] = {2'b10, cp[17:12]};
      r.bytes[2] = {2'b10, cp[11:6]};
      r.bytes[3] = {2'b10, cp[5:0]};
    end
    return r;
  endfunction

endpackage

// ===== hdl/json_string_unescape_utf8.sv =====
// JSON string unescaper to UTF-8: top level joining parser front end, queue and back end.
// An accepted byte's command, if any, is stored in the queue, then in the output register.
// Throughput: one input byte per cycle while the queue is not full and each byte yields
// at most one result; a multi-byte escape leaves the single output register byte by byte.
// Reset (rst_n low, synchronous) returns the parser to waiting for an opening quote and
// empties the queue and output register. Depends on jsu_pkg and the three submodules.
module json_string_unescape_utf8 import jsu_pkg::*; #(
  parameter int FIFO_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_text_byte,
  input  logic       in_end_of_text,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_string_done,
  output logic [3:0] out_error_code,
  output logic       out_last
);

  logic in_fire, full, cmd_push, head_vld, pop;
  cmd_t cmd, head_cmd;

  assign in_ready = !full;
  assign in_fire  = in_valid && in_ready;

  jsu_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_fire        (in_fire),
    .in_text_byte   (in_text_byte),
    .in_end_of_text (in_end_of_text),
    .cmd_push       (cmd_push),
    .cmd            (cmd)
  );

  jsu_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_cmd (cmd),
    .pop      (pop),
    .full     (full),
    .head_vld (head_vld),
    .head_cmd (head_cmd)
  );

  jsu_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_vld        (head_vld),
    .head_cmd        (head_cmd),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_byte_valid  (out_byte_valid),
    .out_string_done (out_string_done),
    .out_error_code  (out_error_code),
    .out_last        (out_last)
  );

endmodule

// ===== hdl/jsu_front.sv =====
// Front end: parser state machine that classifies each input byte into a command.
// Depends on jsu_pkg.
module jsu_front import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic [7:0] in_text_byte,
  input  logic       in_end_of_text,
  output logic       cmd_push,
  output cmd_t       cmd
);

  phase_t      phase_r, phase_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [9:0]  hs_r, hs_nxt;

  logic        cmd_vld;
  logic [4:0]  hex;
  logic [8:0]  esc;
  logic [15:0] acc_new;
  logic [20:0] pair_cp;
  utf8_t       enc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT;
      cnt_r   <= 2'd0;
      acc_r   <= 16'd0;
      hs_r    <= 10'd0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      acc_r   <= acc_nxt;
      hs_r    <= hs_nxt;
    end
  end

  assign hex     = hex_decode(in_text_byte);
  assign esc     = simple_escape(in_text_byte);
  assign acc_new = {acc_r[11:0], hex[3:0]};
  assign pair_cp = SUPP_BASE + {1'b0, hs_r, acc_new[9:0]};
  assign cmd_push = in_fire && cmd_vld;

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    hs_nxt    = hs_r;
    cmd_vld   = 1'b0;
    cmd       = '0;
    enc       = '0;
    if (in_end_of_text) begin
      cmd_vld   = 1'b1;
      phase_nxt = PH_WAIT;
      cnt_nxt   = 2'd0;
      acc_nxt   = 16'd0;
      hs_nxt    = 10'd0;
      unique case (phase_r)
        PH_WAIT: cmd.err = ERR_NO_QUOTE;
        PH_BODY: cmd.err = ERR_UNTERM;
        PH_ESC:  cmd.err = ERR_OPEN_ESC;
        PH_HEX1: cmd.err = ERR_SHORT_UNI;
        default: cmd.err = ERR_UNPAIRED;
      endcase
    end else begin
      unique case (phase_r)
        PH_WAIT: begin
          if (in_text_byte == CH_QUOTE) begin
            phase_nxt = PH_BODY;
          end else begin
            cmd_vld = 1'b1;
            cmd.err = ERR_NO_QUOTE;
          end
        end
        PH_BODY: begin
          if (in_text_byte == CH_QUOTE) begin
            cmd_vld   = 1'b1;
            cmd.done  = 1'b1;
            phase_nxt = PH_WAIT;
          end else if (in_text_byte < CH_SPACE) begin
            cmd_vld   = 1'b1;
            cmd.err   = ERR_CONTROL;
            phase_nxt = PH_WAIT;
          end else if (in_text_byte == CH_BACKSLASH) begin
            phase_nxt = PH_ESC;
          end else begin
            cmd_vld       = 1'b1;
            cmd.is_byte   = 1'b1;
            cmd.bytes[0]  = in_text_byte;
          end
        end
        PH_ESC: begin
          if (in_text_byte == CH_U) begin
            phase_nxt = PH_HEX1;
            cnt_nxt   = 2'd0;
            acc_nxt   = 16'd0;
          end else if (esc[8]) begin
            phase_nxt    = PH_BODY;
            cmd_vld      = 1'b1;
            cmd.is_byte  = 1'b1;
            cmd.bytes[0] = esc[7:0];
          end else begin
            cmd_vld   = 1'b1;
            cmd.err   = ERR_BAD_ESC;
            phase_nxt = PH_WAIT;
          end
        end
        PH_HEX1, PH_HEX2: begin
          if (!hex[4]) begin
            cmd_vld   = 1'b1;
            cmd.err   = (phase_r == PH_HEX1) ? ERR_BAD_HEX : ERR_BAD_LOW_HEX;
            phase_nxt = PH_WAIT;
            cnt_nxt   = 2'd0;
            acc_nxt   = 16'd0;
            hs_nxt    = 10'd0;
          end else if (cnt_r != 2'd3) begin
            cnt_nxt = cnt_r + 2'd1;
            acc_nxt = acc_new;
          end else begin
            cnt_nxt = 2'd0;
            acc_nxt = 16'd0;
            if (phase_r == PH_HEX1) begin
              if (acc_new >= HI_SURR_MIN && acc_new <= HI_SURR_MAX) begin
                hs_nxt    = acc_new[9:0];
                phase_nxt = PH_SEEK_BS;
              end else if (acc_new >= LO_SURR_MIN && acc_new <= LO_SURR_MAX) begin
                cmd_vld   = 1'b1;
                cmd.err   = ERR_UNPAIRED;
                phase_nxt = PH_WAIT;
                hs_nxt    = 10'd0;
              end else begin
                phase_nxt    = PH_BODY;
                enc          = utf8_encode({5'd0, acc_new});
                cmd_vld      = (acc_new != 16'd0);
                cmd.is_byte  = 1'b1;
                cmd.last_idx = enc.last_idx;
                cmd.bytes    = enc.bytes;
              end
            end else begin
              if (acc_new < LO_SURR_MIN || acc_new > LO_SURR_MAX) begin
                cmd_vld   = 1'b1;
                cmd.err   = ERR_UNPAIRED;
                phase_nxt = PH_WAIT;
                hs_nxt    = 10'd0;
              end else begin
                phase_nxt    = PH_BODY;
                hs_nxt       = 10'd0;
                enc          = utf8_encode(pair_cp);
                cmd_vld      = 1'b1;
                cmd.is_byte  = 1'b1;
                cmd.last_idx = enc.last_idx;
                cmd.bytes    = enc.bytes;
              end
            end
          end
        end
        PH_SEEK_BS: begin
          if (in_text_byte == CH_BACKSLASH) begin
            phase_nxt = PH_SEEK_U;
          end else begin
            cmd_vld   = 1'b1;
            cmd.err   = ERR_UNPAIRED;
            phase_nxt = PH_WAIT;
            hs_nxt    = 10'd0;
          end
        end
        PH_SEEK_U: begin
          if (in_text_byte == CH_U) begin
            phase_nxt = PH_HEX2;
            cnt_nxt   = 2'd0;
            acc_nxt   = 16'd0;
          end else begin
            cmd_vld   = 1'b1;
            cmd.err   = ERR_UNPAIRED;
            phase_nxt = PH_WAIT;
            hs_nxt    = 10'd0;
          end
        end
        default: begin
          phase_nxt = PH_WAIT;
          cnt_nxt   = 2'd0;
          acc_nxt   = 16'd0;
          hs_nxt    = 10'd0;
        end
      endcase
    end
  end

endmodule

// ===== hdl/jsu_fifo.sv =====
// Short command queue between the parser front end and the output back end.
// Depends on jsu_pkg for the command type.
module jsu_fifo import jsu_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic full,
  output logic head_vld,
  output cmd_t head_cmd
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full     = (count_r == CW'(DEPTH));
  assign head_vld = (count_r != '0);
  assign head_cmd = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !head_vld |-> !pop)
    else $error("pop from empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count out of range");

endmodule

// ===== hdl/jsu_back.sv =====
// Back end: expands queued commands into the output register, one result per cycle unless out_ready stalls.
// Depends on jsu_pkg.
module jsu_back import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_vld,
  input  cmd_t       head_cmd,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_string_done,
  output logic [3:0] out_error_code,
  output logic       out_last
);

  logic [1:0] idx_r, idx_nxt;
  logic       vld_r, vld_nxt;
  logic [7:0] byte_r;
  logic       bv_r, done_r, last_r;
  logic [3:0] err_r;
  logic       load, is_last;

  assign load    = head_vld && (!vld_r || out_ready);
  assign is_last = !head_cmd.is_byte || (idx_r == head_cmd.last_idx);
  assign pop     = load && is_last;

  always_comb begin
    idx_nxt = idx_r;
    vld_nxt = vld_r;
    if (load) begin
      idx_nxt = is_last ? 2'd0 : idx_r + 2'd1;
      vld_nxt = 1'b1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= head_cmd.is_byte ? head_cmd.bytes[idx_r] : 8'd0;
      bv_r   <= head_cmd.is_byte;
      done_r <= head_cmd.done;
      err_r  <= head_cmd.err;
      last_r <= is_last;
    end
  end

  assign out_valid       = vld_r;
  assign out_byte        = byte_r;
  assign out_byte_valid  = bv_r;
  assign out_string_done = done_r;
  assign out_error_code  = err_r;
  assign out_last        = last_r;

  a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r && (done_r || err_r != ERR_NONE) |-> last_r)
    else $error("done or error result not marked last");
  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> $onehot({bv_r, done_r, err_r != ERR_NONE}))
    else $error("result carries more than one kind");
  a_idx_clear: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> idx_r == 2'd0)
    else $error("byte index not cleared after command");

endmodule

// ===== dv/json_string_unescape_utf8_test.sv =====
// Self-checking test of json_string_unescape_utf8: directed and random JSON string text
// against an in-bench UTF-8 unescape predictor, with random gaps and back-pressure.
// Depends on jsu_pkg and the json_string_unescape_utf8 RTL.
module json_string_unescape_utf8_test;
  timeunit 1ns;
  timeprecision 1ps;
  import jsu_pkg::*;

  localparam int RANDOM_ITEMS = 320;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 8;

  typedef struct packed {
    logic [7:0] data;
    logic       data_ok;
    logic       done;
    logic [3:0] err;
    logic       last_flag;
  } utf8_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_text_byte = 8'h00;
  logic       in_end_of_text = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_byte_valid;
  logic       out_string_done;
  logic [3:0] out_error_code;
  logic       out_last;

  utf8_result_t utf8_expect_q[$];
  logic [8:0]   text_q[$];
  int           fail_cnt = 0;
  int           items_sent = 0;
  int           cycle_cnt = 0;
  logic         burst = 1'b0;

  phase_t       parse_phase = PH_WAIT;
  logic [1:0]   digit_cnt = 2'd0;
  logic [15:0]  code_acc = 16'd0;
  logic [9:0]   hi_surr_bits = 10'd0;

  json_string_unescape_utf8 uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_text_byte    (in_text_byte),
    .in_end_of_text  (in_end_of_text),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_byte_valid  (out_byte_valid),
    .out_string_done (out_string_done),
    .out_error_code  (out_error_code),
    .out_last        (out_last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic utf8_result_t mk_result(input logic [7:0] d, input logic dv,
                                             input logic dn, input logic [3:0] e);
    utf8_result_t r;
    r.data      = d;
    r.data_ok   = dv;
    r.done      = dn;
    r.err       = e;
    r.last_flag = 1'b0;
    return r;
  endfunction

  task automatic expect_add(input utf8_result_t r);
    utf8_expect_q.insert(utf8_expect_q.size(), r);
  endtask

  task automatic clear_parse;
    parse_phase  = PH_WAIT;
    digit_cnt    = 2'd0;
    code_acc     = 16'd0;
    hi_surr_bits = 10'd0;
  endtask

  task automatic parse_error(input logic [3:0] code);
    clear_parse();
    expect_add(mk_result(8'h00, 1'b0, 1'b0, code));
  endtask

  task automatic push_byte(input logic [7:0] b);
    expect_add(mk_result(b, 1'b1, 1'b0, ERR_NONE));
  endtask

  task automatic emit_utf8(input logic [20:0] cp);
    if (cp == 21'd0) begin
      // drop code point zero
    end else if (cp < 21'h80) begin
      push_byte(cp[7:0]);
    end else if (cp < 21'h800) begin
      push_byte(8'hC0 | 8'(cp >> 6));
      push_byte(8'h80 | 8'(cp & 21'h3F));
    end else if (cp < 21'h10000) begin
      push_byte(8'hE0 | 8'(cp >> 12));
      push_byte(8'h80 | 8'((cp >> 6) & 21'h3F));
      push_byte(8'h80 | 8'(cp & 21'h3F));
    end else begin
      push_byte(8'hF0 | 8'(cp >> 18));
      push_byte(8'h80 | 8'((cp >> 12) & 21'h3F));
      push_byte(8'h80 | 8'((cp >> 6) & 21'h3F));
      push_byte(8'h80 | 8'(cp & 21'h3F));
    end
  endtask

  task automatic unescape_predict(input logic [7:0] c, input logic eot);
    int           n0;
    logic         hex_ok;
    logic [7:0]   digit_val;
    logic [20:0]  cp;
    utf8_result_t r;
    n0 = utf8_expect_q.size();
    hex_ok = 1'b1;
    digit_val = 8'h00;
    if (c >= "0" && c <= "9") digit_val = c - "0";
    else if (c >= "a" && c <= "f") digit_val = c - "a" + 8'd10;
    else if (c >= "A" && c <= "F") digit_val = c - "A" + 8'd10;
    else hex_ok = 1'b0;
    if (eot) begin
      case (parse_phase)
        PH_WAIT: parse_error(ERR_NO_QUOTE);
        PH_BODY: parse_error(ERR_UNTERM);
        PH_ESC:  parse_error(ERR_OPEN_ESC);
        PH_HEX1: parse_error(ERR_SHORT_UNI);
        default: parse_error(ERR_UNPAIRED);
      endcase
    end else begin
      case (parse_phase)
        PH_WAIT: begin
          if (c == CH_QUOTE) parse_phase = PH_BODY;
          else parse_error(ERR_NO_QUOTE);
        end
        PH_BODY: begin
          if (c == CH_QUOTE) begin
            clear_parse();
            expect_add(mk_result(8'h00, 1'b0, 1'b1, ERR_NONE));
          end else if (c < CH_SPACE) begin
            parse_error(ERR_CONTROL);
          end else if (c == CH_BACKSLASH) begin
            parse_phase = PH_ESC;
          end else begin
            push_byte(c);
          end
        end
        PH_ESC: begin
          if (c == CH_U) begin
            parse_phase = PH_HEX1;
            digit_cnt   = 2'd0;
            code_acc    = 16'd0;
          end else begin
            case (c)
              CH_QUOTE:     push_byte(CH_QUOTE);
              CH_BACKSLASH: push_byte(CH_BACKSLASH);
              "/":          push_byte("/");
              "b":          push_byte(8'h08);
              "f":          push_byte(8'h0C);
              "n":          push_byte(8'h0A);
              "r":          push_byte(8'h0D);
              "t":          push_byte(8'h09);
              default:      parse_error(ERR_BAD_ESC);
            endcase
            if (parse_phase == PH_ESC) parse_phase = PH_BODY;
          end
        end
        PH_HEX1, PH_HEX2: begin
          if (!hex_ok) begin
            parse_error(parse_phase == PH_HEX1 ? ERR_BAD_HEX : ERR_BAD_LOW_HEX);
          end else begin
            code_acc = {code_acc[11:0], digit_val[3:0]};
            if (digit_cnt != 2'd3) begin
              digit_cnt = digit_cnt + 2'd1;
            end else begin
              digit_cnt = 2'd0;
              if (parse_phase == PH_HEX1) begin
                if (code_acc >= HI_SURR_MIN && code_acc <= HI_SURR_MAX) begin
                  hi_surr_bits = code_acc[9:0];
                  parse_phase  = PH_SEEK_BS;
                end else if (code_acc >= LO_SURR_MIN && code_acc <= LO_SURR_MAX) begin
                  parse_error(ERR_UNPAIRED);
                end else begin
                  parse_phase = PH_BODY;
                  emit_utf8({5'd0, code_acc});
                end
              end else begin
                if (code_acc < LO_SURR_MIN || code_acc > LO_SURR_MAX) begin
                  parse_error(ERR_UNPAIRED);
                end else begin
                  cp = SUPP_BASE + {1'b0, hi_surr_bits, code_acc[9:0]};
                  parse_phase  = PH_BODY;
                  hi_surr_bits = 10'd0;
                  emit_utf8(cp);
                end
              end
              code_acc = 16'd0;
            end
          end
        end
        PH_SEEK_BS: begin
          if (c == CH_BACKSLASH) parse_phase = PH_SEEK_U;
          else parse_error(ERR_UNPAIRED);
        end
        PH_SEEK_U: begin
          if (c == CH_U) begin
            parse_phase = PH_HEX2;
            digit_cnt   = 2'd0;
            code_acc    = 16'd0;
          end else begin
            parse_error(ERR_UNPAIRED);
          end
        end
        default: clear_parse();
      endcase
    end
    if (utf8_expect_q.size() > n0) begin
      r = utf8_expect_q.pop_back();
      r.last_flag = 1'b1;
      expect_add(r);
    end
  endtask

  task automatic send_item(input logic [7:0] b, input logic eot);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_text_byte   <= b;
    in_end_of_text <= eot;
    do @(posedge clk); while (in_ready !== 1'b1);
    unescape_predict(b, eot);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic send_eot;
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic wait_drained;
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
      guard++;
    end while (utf8_expect_q.size() != 0 && guard < DRAIN_LIMIT);
    if (utf8_expect_q.size() != 0) begin
      $error("%0d expected results never arrived", utf8_expect_q.size());
      fail_cnt++;
      utf8_expect_q.delete();
    end
  endtask

  task automatic check_result;
    utf8_result_t want;
    if (utf8_expect_q.size() == 0) begin
      $error("unexpected result: byte %02h valid %0b done %0b error %0d last %0b",
             out_byte, out_byte_valid, out_string_done, out_error_code, out_last);
      fail_cnt++;
    end else begin
      want = utf8_expect_q.pop_front();
      if (out_byte !== want.data) begin
        $error("out_byte: expected %02h, got %02h", want.data, out_byte);
        fail_cnt++;
      end
      if (out_byte_valid !== want.data_ok) begin
        $error("out_byte_valid: expected %0b, got %0b", want.data_ok, out_byte_valid);
        fail_cnt++;
      end
      if (out_string_done !== want.done) begin
        $error("out_string_done: expected %0b, got %0b", want.done, out_string_done);
        fail_cnt++;
      end
      if (out_error_code !== want.err) begin
        $error("out_error_code: expected %0d, got %0d", want.err, out_error_code);
        fail_cnt++;
      end
      if (out_last !== want.last_flag) begin
        $error("out_last: expected %0b, got %0b", want.last_flag, out_last);
        fail_cnt++;
      end
    end
  endtask

  initial begin : result_sink
    int stall;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      stall = burst ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      check_result();
    end
  end

  task automatic add_entry(input logic [8:0] e);
    text_q.insert(text_q.size(), e);
  endtask

  task automatic add_byte(input logic [7:0] b);
    add_entry({1'b0, b});
  endtask

  task automatic add_unicode(input logic [15:0] v);
    int         i;
    logic [3:0] nib;
    add_byte(CH_BACKSLASH);
    add_byte(CH_U);
    for (i = 3; i >= 0; i--) begin
      nib = v[4*i +: 4];
      if (nib < 4'd10) add_byte("0" + {4'd0, nib});
      else if ($urandom_range(0, 1) == 0) add_byte("a" + {4'd0, nib} - 8'd10);
      else add_byte("A" + {4'd0, nib} - 8'd10);
    end
  endtask

  task automatic test_waiting_errors;
    send_text("x");
    send_eot();
    send_item(8'h00, 1'b0);
  endtask

  task automatic test_body_cases;
    send_text("\" ~");
    send_item(8'h7F, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'hFF, 1'b0);
    send_text("\"");
    send_text("\"");
    send_item(8'h1F, 1'b0);
    send_text("\"");
    send_eot();
  endtask

  task automatic test_escape_cases;
    send_text("\"\\\"\\\\\\/\\b\\f\\n\\r\\t\"");
    send_text("\"\\");
    send_eot();
    send_text("\"\\v");
  endtask

  task automatic test_unicode_cases;
    send_text("\"\\u0000\\u007f\\u0080\\u07FF\\u0800\\uffFF\"");
    send_text("\"\\u0");
    send_eot();
    send_text("\"\\u00g");
  endtask

  task automatic test_surrogate_cases;
    send_text("\"\\uD800\\uDC00\\uDBFF\\uDFFF\"");
    send_text("\"\\uDC00");
    send_text("\"\\uD800x");
    send_text("\"\\uDBFF\\x");
    send_text("\"\\uDBFF\\u0041");
    send_text("\"\\uD800\\uDCZ");
    send_text("\"\\uD800\\u");
    send_eot();
    send_text("\"\\uD800\\");
    send_eot();
  endtask

  task automatic test_random_strings;
    int         start;
    int         tokens;
    int         kind;
    int         pos;
    int         k;
    logic [7:0] b;
    logic [15:0] v;
    logic [8:0] junk;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      burst = ($urandom_range(0, 7) == 0);
      text_q.delete();
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 5) == 0) add_entry({1'b1, 8'($urandom_range(0, 255))});
          else if ($urandom_range(0, 3) == 0) add_byte(CH_QUOTE);
          else add_byte(8'($urandom_range(0, 255)));
        end
      end else begin
        add_byte(CH_QUOTE);
        tokens = $urandom_range(0, 6);
        repeat (tokens) begin
          kind = $urandom_range(0, 11);
          if (kind < 4) begin
            do b = 8'($urandom_range(32, 127)); while (b == CH_QUOTE || b == CH_BACKSLASH);
            add_byte(b);
          end else if (kind == 4) begin
            add_byte(8'($urandom_range(128, 255)));
          end else if (kind < 7) begin
            add_byte(CH_BACKSLASH);
            case ($urandom_range(0, 7))
              0:       add_byte(CH_QUOTE);
              1:       add_byte(CH_BACKSLASH);
              2:       add_byte("/");
              3:       add_byte("b");
              4:       add_byte("f");
              5:       add_byte("n");
              6:       add_byte("r");
              default: add_byte("t");
            endcase
          end else if (kind < 9) begin
            case ($urandom_range(0, 3))
              0:       v = 16'h0000;
              1:       v = 16'($urandom_range(1, 16'h7F));
              2:       v = 16'($urandom_range(16'h80, 16'h7FF));
              default: begin
                v = 16'($urandom_range(16'h800, 16'hFFFF));
                if (v >= HI_SURR_MIN && v <= LO_SURR_MAX) v = v ^ 16'h4000;
              end
            endcase
            add_unicode(v);
          end else if (kind < 11) begin
            add_unicode(16'($urandom_range(HI_SURR_MIN, HI_SURR_MAX)));
            if ($urandom_range(0, 7) == 0) v = 16'($urandom_range(0, 16'hFFFF));
            else v = 16'($urandom_range(LO_SURR_MIN, LO_SURR_MAX));
            add_unicode(v);
          end else if ($urandom_range(0, 1) == 0) begin
            add_unicode(16'($urandom_range(LO_SURR_MIN, LO_SURR_MAX)));
          end else begin
            add_unicode(16'($urandom_range(HI_SURR_MIN, HI_SURR_MAX)));
          end
        end
        add_byte(CH_QUOTE);
        pos = $urandom_range(1, text_q.size() - 1);
        case ($urandom_range(0, 9))
          0: text_q[pos] = {1'b0, 8'($urandom_range(0, 255))};
          1: begin
            while (text_q.size() > pos) junk = text_q.pop_back();
            add_entry({1'b1, 8'($urandom_range(0, 255))});
          end
          2: text_q[pos] = {1'b0, 8'($urandom_range(0, 31))};
          default: ;
        endcase
      end
      for (k = 0; k < text_q.size(); k++) send_item(text_q[k][7:0], text_q[k][8]);
      if ($urandom_range(0, 19) == 0) wait_drained();
    end
    burst = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_waiting_errors();
    test_body_cases();
    test_escape_cases();
    test_unicode_cases();
    test_surrogate_cases();
    wait_drained();
    test_random_strings();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/jsu_pkg.sv
hdl/jsu_front.sv
hdl/jsu_fifo.sv
hdl/jsu_back.sv
hdl/json_string_unescape_utf8.sv
dv/json_string_unescape_utf8_test.sv
